>>> rtl/pbrct_pkg.sv
// Shared types, constants and arithmetic helpers for the Cook-Torrance light pipeline.
// No dependencies.
`default_nettype none
package pbrct_pkg;

  typedef struct packed {
    logic [47:0] surface_normal;
    logic [47:0] view_dir;
    logic [47:0] light_dir;
    logic [47:0] half_vector;
    logic [15:0] albedo_red;
    logic [15:0] albedo_green;
    logic [15:0] albedo_blue;
    logic [15:0] metallic;
    logic [15:0] roughness;
    logic [15:0] radiance_red;
    logic [15:0] radiance_green;
    logic [15:0] radiance_blue;
  } in_t;

  typedef struct packed {
    logic [15:0] color_red;
    logic [15:0] color_green;
    logic [15:0] color_blue;
  } out_t;

  localparam logic [16:0] FX_ONE   = 17'd65536;
  localparam logic [17:0] FX_PI    = 18'd205887;
  localparam logic [11:0] FX_F0_DI = 12'd2621;

  // floor(2^48 / pi_fx): reciprocal for the diffuse divide
  localparam longint unsigned PiRecipWide = (64'd1 << 48) / 64'd205887;
  localparam logic [30:0] PI_RECIP = 31'(PiRecipWide);

  localparam int DIV_NUM_W = 48;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEPS_PER_STAGE;

  function automatic logic [31:0] sat32(input logic [63:0] x);
    return (|x[63:32]) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // Q1.15 to Q1.16, clamped at 1.0
  function automatic logic [16:0] uin(input logic [15:0] v);
    return (v > 16'd32768) ? FX_ONE : {v, 1'b0};
  endfunction

  // restoring division steps; returns {remainder, shifted numerator/quotient}
  function automatic logic [32+DIV_NUM_W-1:0] div_step(input logic [31:0] rem_i,
                                                        input logic [DIV_NUM_W-1:0] nq_i,
                                                        input logic [31:0] den_i);
    logic [32:0] t;
    logic [31:0] rem;
    logic [DIV_NUM_W-1:0] nq;
    rem = rem_i;
    nq  = nq_i;
    for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
      t  = {rem, nq[DIV_NUM_W-1]};
      nq = {nq[DIV_NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_i}) begin
        t     = t - {1'b0, den_i};
        nq[0] = 1'b1;
      end
      rem = t[31:0];
    end
    return {rem, nq};
  endfunction

endpackage
`default_nettype wire

>>> rtl/pbrct_div.sv
// Pipelined restoring divider: floor((num) / max(den,1)), quotient saturated to 32 bits.
// Depends on pbrct_pkg. One transaction per cycle while en is high; en low holds every stage.
`default_nettype none
module pbrct_div import pbrct_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [31:0]          den,
  output logic [31:0]          quo
);

  logic [DIV_NUM_W-1:0] nq_r  [DIV_STAGES];
  logic [31:0]          rem_r [DIV_STAGES];
  logic [31:0]          den_r [DIV_STAGES];
  logic [31:0]          den_in;

  assign den_in = (den == 32'd0) ? 32'd1 : den;

  always_ff @(posedge clk) begin
    if (en) begin
      {rem_r[0], nq_r[0]} <= div_step(32'd0, num, den_in);
      den_r[0] <= den_in;
      for (int s = 1; s < DIV_STAGES; s++) begin
        {rem_r[s], nq_r[s]} <= div_step(rem_r[s-1], nq_r[s-1], den_r[s-1]);
        den_r[s] <= den_r[s-1];
      end
    end
  end

  assign quo = (|nq_r[DIV_STAGES-1][DIV_NUM_W-1:32]) ? 32'hFFFF_FFFF
                                                     : nq_r[DIV_STAGES-1][31:0];

endmodule
`default_nettype wire

>>> rtl/pbr_cook_torrance_light.sv
// Cook-Torrance (GGX / Smith-Schlick / Schlick Fresnel) light for one light at one pixel.
// Throughput one transaction per cycle while in_ready is high.
// Depth is set by two 24-stage pipelined dividers in series (geometry/GGX, then specular).
// A two-entry output register and skid stage part the sides; in_ready drops only when both hold.
// Reset clears the stage valid bits and output flags; payload registers are not reset.
// Depends on pbrct_pkg and pbrct_div.
`default_nettype none
module pbr_cook_torrance_light import pbrct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int DOT_NV = 0;
  localparam int DOT_NL = 1;
  localparam int DOT_NH = 2;
  localparam int DOT_HV = 3;

  logic en;

  // stage registers, indexed by stage
  logic               v_r      [1:61];
  logic signed [31:0] dp_r     [4][3];
  logic [16:0]        m_r      [1:4];
  logic [16:0]        r1_r;
  logic [2:0][16:0]   alb_r    [1:8];
  logic [2:0][15:0]   rad_r    [1:58];
  logic [19:0]        nv_r     [2:6];
  logic [19:0]        nl_r     [2:59];
  logic [19:0]        nh_r;
  logic [19:0]        hv_r;
  logic [16:0]        alpha_r;
  logic [18:0]        rp_r;
  logic [16:0]        invm_r   [2:7];
  logic [16:0]        a2_r     [3:6];
  logic [23:0]        nh2_r;
  logic [15:0]        k_r;
  logic [16:0]        s_r      [3:5];
  logic [23:0]        nvnl_r;
  logic [23:0]        prod_r;
  logic [16:0]        sq2_r;
  logic [20:0]        gdv_r    [4:6];
  logic [20:0]        gdl_r    [4:6];
  logic [25:0]        sden_r   [4:33];
  logic [30:0]        magsq_r;
  logic [16:0]        sq4_r;
  logic [2:0][16:0]   f0_r     [5:6];
  logic [31:0]        ggx_r;
  logic [16:0]        sq5_r;
  logic [2:0][16:0]   f_r      [7:32];
  logic [2:0][16:0]   kd_r;
  logic [2:0][16:0]   ka_r     [9:11];
  logic [2:0][47:0]   pm_r;
  logic [2:0][14:0]   q0_r;
  logic [2:0][32:0]   t_r;
  logic [2:0][14:0]   diff_r   [12:57];
  logic [31:0]        geo_r;
  logic [31:0]        dist_r;
  logic [31:0]        dg_r;
  logic [2:0][31:0]   sf_r;
  logic [2:0][31:0]   tot_r;
  logic [2:0][31:0]   tr_r;
  logic [2:0][31:0]   tn_r;
  logic [2:0][15:0]   col_r;

  // output register and skid
  logic       out_v_r;
  logic       skid_v_r;
  out_t       out_r;
  out_t       skid_r;

  // combinational next values
  logic [47:0]        va [4];
  logic [47:0]        vb [4];
  logic signed [31:0] dp_nxt [4][3];
  logic [19:0]        dot_nxt [4];
  logic [2:0][16:0]   alb_nxt;
  logic [2:0][15:0]   rad_nxt;
  logic [33:0]        alpha_p;
  logic [17:0]        rp1;
  logic [35:0]        rp_p;
  logic [33:0]        a2_p;
  logic [39:0]        nh2_p;
  logic [39:0]        nvnl_p;
  logic [16:0]        s_nxt;
  logic [16:0]        omk;
  logic [36:0]        gdv_p;
  logic [36:0]        gdl_p;
  logic [40:0]        prod_p;
  logic [33:0]        sq2_p;
  logic [23:0]        mag;
  logic [47:0]        magsq_p;
  logic [33:0]        sq4_p;
  logic [2:0][33:0]   f0_p;
  logic [48:0]        ggx_p;
  logic [33:0]        sq5_p;
  logic [2:0][33:0]   fm_p;
  logic [2:0][17:0]   f_sum;
  logic [2:0][16:0]   f_nxt;
  logic [2:0][33:0]   kd_p;
  logic [2:0][33:0]   ka_p;
  logic [2:0][47:0]   pm_nxt;
  logic [2:0][32:0]   t_nxt;
  logic [2:0][32:0]   rem_c;
  logic [2:0][14:0]   diff_nxt;
  logic [63:0]        geo_p;
  logic [63:0]        dg_p;
  logic [2:0][48:0]   sf_p;
  logic [2:0][32:0]   tot_p;
  logic [2:0][47:0]   tr_p;
  logic [2:0][51:0]   tn_p;
  logic [2:0][15:0]   col_nxt;
  logic [31:0]        dist_q;
  logic [31:0]        gv_q;
  logic [31:0]        gl_q;
  logic [2:0][31:0]   spec_q;
  out_t               pd;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // stage 1: component products
  always_comb begin
    va[DOT_NV] = in_data.surface_normal;  vb[DOT_NV] = in_data.view_dir;
    va[DOT_NL] = in_data.surface_normal;  vb[DOT_NL] = in_data.light_dir;
    va[DOT_NH] = in_data.surface_normal;  vb[DOT_NH] = in_data.half_vector;
    va[DOT_HV] = in_data.half_vector;     vb[DOT_HV] = in_data.view_dir;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        dp_nxt[j][i] = signed'(va[j][16*i +: 16]) * signed'(vb[j][16*i +: 16]);
      end
    end
    alb_nxt = {uin(in_data.albedo_red), uin(in_data.albedo_green), uin(in_data.albedo_blue)};
    rad_nxt = {in_data.radiance_red, in_data.radiance_green, in_data.radiance_blue};
  end

  // stage 2: clamped dots, alpha, (r+1)^2
  logic signed [33:0] dsum [4];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      dsum[j] = 34'(dp_r[j][0]) + 34'(dp_r[j][1]) + 34'(dp_r[j][2]);
      dot_nxt[j] = (dsum[j] <= 34'sd0) ? 20'd0 : dsum[j][31:12];
    end
  end
  assign alpha_p = r1_r * r1_r;
  assign rp1     = 18'(r1_r) + 18'(FX_ONE);
  assign rp_p    = rp1 * rp1;

  // stage 3
  assign a2_p   = alpha_r * alpha_r;
  assign nh2_p  = nh_r * nh_r;
  assign nvnl_p = nv_r[2] * nl_r[2];
  assign s_nxt  = (hv_r >= 20'(FX_ONE)) ? 17'd0 : 17'(20'(FX_ONE) - hv_r);

  // stage 4
  assign omk    = FX_ONE - 17'(k_r);
  assign gdv_p  = nv_r[3] * omk;
  assign gdl_p  = nl_r[3] * omk;
  assign prod_p = nh2_r * (FX_ONE - a2_r[3]);
  assign sq2_p  = s_r[3] * s_r[3];

  // stage 5
  assign mag     = (prod_r >= 24'(FX_ONE)) ? prod_r - 24'(FX_ONE) : 24'(FX_ONE) - prod_r;
  assign magsq_p = mag * mag;
  assign sq4_p   = sq2_r * sq2_r;

  // stage 6
  assign ggx_p = FX_PI * magsq_r;
  assign sq5_p = sq4_r * s_r[5];

  // stages 5 and 7..12: per-channel Fresnel and diffuse
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      f0_p[c]    = 34'(FX_F0_DI) * 34'(invm_r[4]) + 34'(alb_r[4][c]) * 34'(m_r[4]);
      fm_p[c]    = (FX_ONE - f0_r[6][c]) * sq5_r;
      f_sum[c]   = 18'(f0_r[6][c]) + 18'(fm_p[c][32:16]);
      f_nxt[c]   = (f_sum[c] > 18'(FX_ONE)) ? FX_ONE : f_sum[c][16:0];
      kd_p[c]    = (FX_ONE - f_r[7][c]) * invm_r[7];
      ka_p[c]    = kd_r[c] * alb_r[8][c];
      pm_nxt[c]  = ka_r[9][c] * PI_RECIP;
      t_nxt[c]   = pm_r[c][46:32] * FX_PI;
      rem_c[c]   = {ka_r[11][c], 16'd0} - t_r[c];
      diff_nxt[c] = (rem_c[c] >= 33'(FX_PI)) ? q0_r[c] + 15'd1 : q0_r[c];
    end
  end

  // geometry and GGX dividers, launched from stage 6, results at stage 30
  pbrct_div u_div_dist (
    .clk (clk), .en (en),
    .num ({15'd0, a2_r[6], 16'd0}), .den (ggx_r), .quo (dist_q)
  );
  pbrct_div u_div_gv (
    .clk (clk), .en (en),
    .num ({12'd0, nv_r[6], 16'd0}), .den ({11'd0, gdv_r[6]}), .quo (gv_q)
  );
  pbrct_div u_div_gl (
    .clk (clk), .en (en),
    .num ({12'd0, nl_r[6], 16'd0}), .den ({11'd0, gdl_r[6]}), .quo (gl_q)
  );

  assign geo_p = gv_q * gl_q;
  assign dg_p  = dist_r * geo_r;

  // specular dividers, launched from stage 33, results at stage 57
  for (genvar c = 0; c < 3; c++) begin : g_spec
    assign sf_p[c] = dg_r * f_r[32][c];
    pbrct_div u_div_spec (
      .clk (clk), .en (en),
      .num ({sf_r[c], 16'd0}), .den ({6'd0, sden_r[33]}), .quo (spec_q[c])
    );
    assign tot_p[c]   = 33'(diff_r[57][c]) + 33'(spec_q[c]);
    assign tr_p[c]    = tot_r[c] * rad_r[58][c];
    assign tn_p[c]    = tr_r[c] * nl_r[59];
    assign col_nxt[c] = (|tn_r[c][31:24]) ? 16'hFFFF : tn_r[c][23:8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r <= dp_nxt;
      m_r[1] <= uin(in_data.metallic);
      r1_r <= uin(in_data.roughness);
      alb_r[1] <= alb_nxt;
      rad_r[1] <= rad_nxt;
      for (int i = 2; i <= 4; i++) m_r[i] <= m_r[i-1];
      for (int i = 2; i <= 8; i++) alb_r[i] <= alb_r[i-1];
      for (int i = 2; i <= 58; i++) rad_r[i] <= rad_r[i-1];

      nv_r[2] <= dot_nxt[DOT_NV];
      nl_r[2] <= dot_nxt[DOT_NL];
      nh_r <= dot_nxt[DOT_NH];
      hv_r <= dot_nxt[DOT_HV];
      alpha_r <= alpha_p[32:16];
      rp_r <= rp_p[34:16];
      invm_r[2] <= FX_ONE - m_r[1];
      for (int i = 3; i <= 6; i++) nv_r[i] <= nv_r[i-1];
      for (int i = 3; i <= 59; i++) nl_r[i] <= nl_r[i-1];
      for (int i = 3; i <= 7; i++) invm_r[i] <= invm_r[i-1];

      a2_r[3] <= a2_p[32:16];
      nh2_r <= nh2_p[39:16];
      k_r <= rp_r[18:3];
      s_r[3] <= s_nxt;
      nvnl_r <= nvnl_p[39:16];
      for (int i = 4; i <= 6; i++) a2_r[i] <= a2_r[i-1];
      for (int i = 4; i <= 5; i++) s_r[i] <= s_r[i-1];

      prod_r <= prod_p[39:16];
      sq2_r <= sq2_p[32:16];
      gdv_r[4] <= 21'(gdv_p[36:16]) + 21'(k_r);
      gdl_r[4] <= 21'(gdl_p[36:16]) + 21'(k_r);
      sden_r[4] <= {nvnl_r, 2'b00};
      for (int i = 5; i <= 6; i++) begin
        gdv_r[i] <= gdv_r[i-1];
        gdl_r[i] <= gdl_r[i-1];
      end
      for (int i = 5; i <= 33; i++) sden_r[i] <= sden_r[i-1];

      magsq_r <= magsq_p[46:16];
      sq4_r <= sq4_p[32:16];
      for (int c = 0; c < 3; c++) f0_r[5][c] <= f0_p[c][32:16];
      f0_r[6] <= f0_r[5];

      ggx_r <= sat32(64'(ggx_p[48:16]));
      sq5_r <= sq5_p[32:16];

      f_r[7] <= f_nxt;
      for (int i = 8; i <= 32; i++) f_r[i] <= f_r[i-1];
      for (int c = 0; c < 3; c++) begin
        kd_r[c] <= kd_p[c][32:16];
        ka_r[9][c] <= ka_p[c][32:16];
        q0_r[c] <= pm_r[c][46:32];
        sf_r[c] <= sat32(64'(sf_p[c][48:16]));
        tot_r[c] <= sat32(64'(tot_p[c]));
        tr_r[c] <= sat32(64'(tr_p[c][47:8]));
        tn_r[c] <= sat32(64'(tn_p[c][51:16]));
      end
      for (int i = 10; i <= 11; i++) ka_r[i] <= ka_r[i-1];
      pm_r <= pm_nxt;
      t_r <= t_nxt;
      diff_r[12] <= diff_nxt;
      for (int i = 13; i <= 57; i++) diff_r[i] <= diff_r[i-1];

      geo_r <= sat32(64'(geo_p[63:16]));
      dist_r <= dist_q;
      dg_r <= sat32(64'(dg_p[63:16]));
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 61; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int i = 2; i <= 61; i++) v_r[i] <= v_r[i-1];
    end
  end

  assign pd = '{color_red: col_r[2], color_green: col_r[1], color_blue: col_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (v_r[61]) begin
      if (out_v_r && !out_ready) begin
        skid_v_r <= 1'b1;
      end
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (v_r[61]) begin
      if (out_v_r && !out_ready) begin
        skid_r <= pd;
      end else begin
        out_r <= pd;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> rtl/pbrct_chk.sv
// Port-level checks for pbr_cook_torrance_light, attached by bind.
// Depends on pbrct_pkg.
`default_nettype none
module pbrct_chk import pbrct_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result transaction changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule

bind pbr_cook_torrance_light pbrct_chk u_chk (.*);
`default_nettype wire
